// File: rtl/core/tgus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt gesture unlock sequencer: shared definitions
// Codes, transaction and configuration types, reset values and the
// accelerometer scaling function.
// ----------------------------------------------------------------------------
package tgus_pkg;

	localparam int ACC_W       = 14;
	localparam int SCL_W       = 9;
	localparam int CMP_W       = 10;
	localparam int PROD_W      = 21;
	localparam int SCALE_NUM   = 100;
	localparam int SCALE_SHIFT = 12;
	localparam int MS_W        = 16;
	localparam int LVL_W       = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [MS_W-1:0]  FLAT_HOLD_MIN_RST  = 16'd10000;
	localparam logic [MS_W-1:0]  RIGHT_HOLD_MIN_RST = 16'd2000;
	localparam logic [MS_W-1:0]  RIGHT_HOLD_MAX_RST = 16'd6000;
	localparam logic [MS_W-1:0]  UP_HOLD_MIN_RST    = 16'd4000;
	localparam logic [MS_W-1:0]  UP_HOLD_MAX_RST    = 16'd8000;
	localparam logic [MS_W-1:0]  CONFIRM_WINDOW_RST = 16'd500;
	localparam logic [LVL_W-1:0] ENTER_LEVEL_RST    = 7'd90;
	localparam logic [LVL_W-1:0] EXIT_LEVEL_RST     = 7'd80;
	localparam logic [MS_W-1:0]  MS_MAX             = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLAT_HOLD_MIN  = 3'd0,
		REG_RIGHT_HOLD_MIN = 3'd1,
		REG_RIGHT_HOLD_MAX = 3'd2,
		REG_UP_HOLD_MIN    = 3'd3,
		REG_UP_HOLD_MAX    = 3'd4,
		REG_CONFIRM_WINDOW = 3'd5,
		REG_ENTER_LEVEL    = 3'd6,
		REG_EXIT_LEVEL     = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		OR_INTER = 3'd0,
		OR_FLAT  = 3'd1,
		OR_OVER  = 3'd2,
		OR_RIGHT = 3'd3,
		OR_LEFT  = 3'd4,
		OR_UP    = 3'd5,
		OR_DOWN  = 3'd6
	} orient_t;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_FLAT  = 3'd1,
		PH_RIGHT = 3'd2,
		PH_UP    = 3'd3,
		PH_TRIG  = 3'd4,
		PH_TERR  = 3'd5,
		PH_SERR  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_FLAT   = 3'd1,
		EV_RIGHT  = 3'd2,
		EV_UP     = 3'd3,
		EV_CHANGE = 3'd4
	} event_t;

	typedef struct packed {
		logic    tick;
		event_t  ev;
		orient_t orient;
	} qentry_t;

	typedef struct packed {
		logic [MS_W-1:0]  flat_hold_min;
		logic [MS_W-1:0]  right_hold_min;
		logic [MS_W-1:0]  right_hold_max;
		logic [MS_W-1:0]  up_hold_min;
		logic [MS_W-1:0]  up_hold_max;
		logic [MS_W-1:0]  confirm_window;
		logic [LVL_W-1:0] enter_level;
		logic [LVL_W-1:0] exit_level;
	} cfg_t;

	function automatic logic signed [SCL_W-1:0] scale_acc(input logic signed [ACC_W-1:0] v);
		logic signed [PROD_W-1:0] p;
		logic signed [PROD_W-1:0] q;
		p = PROD_W'(v) * PROD_W'(SCALE_NUM);
		if (p < 0) begin
			p = p + PROD_W'((1 << SCALE_SHIFT) - 1);
		end
		q = p >>> SCALE_SHIFT;
		return q[SCL_W-1:0];
	endfunction

endpackage

// File: rtl/core/tilt_gesture_unlock_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt gesture unlock sequencer
// Classifies accelerometer samples into orientations and checks the gesture
// flat, right, up, flat against configurable hold and confirm windows.
// ----------------------------------------------------------------------------
// One transaction in, one result out, one transaction accepted per clock while
// the queue is not full. The front end scales and classifies a sample in the
// cycle it is accepted and writes a tick or event entry into a QUEUE_DEPTH-
// entry queue; the sequencer pops one entry per cycle into its output register
// while the output is not stalled, so a result is offered once its entry has
// passed through the queue and the output register. The input stalls only when
// the queue is full, i.e. after QUEUE_DEPTH transactions pile up in the queue
// behind a stalled output. Configuration registers take effect on the next cycle.
module tilt_gesture_unlock_sequencer #(
	parameter int QUEUE_DEPTH = tgus_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wen,
	input  logic [tgus_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tgus_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   mode,
	input  logic signed [tgus_pkg::ACC_W-1:0]      accel_x,
	input  logic signed [tgus_pkg::ACC_W-1:0]      accel_y,
	input  logic signed [tgus_pkg::ACC_W-1:0]      accel_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [2:0]                             orientation,
	output logic [2:0]                             sequence_phase,
	output logic [2:0]                             step_leds,
	output logic                                   error_lamp,
	output logic                                   success_lamp
);
	import tgus_pkg::*;

	cfg_t    cfg_q;
	qentry_t f_entry;
	qentry_t q_entry;
	logic    accept;
	logic    q_full;
	logic    q_not_empty;
	logic    pop;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flat_hold_min  <= FLAT_HOLD_MIN_RST;
			cfg_q.right_hold_min <= RIGHT_HOLD_MIN_RST;
			cfg_q.right_hold_max <= RIGHT_HOLD_MAX_RST;
			cfg_q.up_hold_min    <= UP_HOLD_MIN_RST;
			cfg_q.up_hold_max    <= UP_HOLD_MAX_RST;
			cfg_q.confirm_window <= CONFIRM_WINDOW_RST;
			cfg_q.enter_level    <= ENTER_LEVEL_RST;
			cfg_q.exit_level     <= EXIT_LEVEL_RST;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_FLAT_HOLD_MIN:  cfg_q.flat_hold_min  <= cfg_wdata;
				REG_RIGHT_HOLD_MIN: cfg_q.right_hold_min <= cfg_wdata;
				REG_RIGHT_HOLD_MAX: cfg_q.right_hold_max <= cfg_wdata;
				REG_UP_HOLD_MIN:    cfg_q.up_hold_min    <= cfg_wdata;
				REG_UP_HOLD_MAX:    cfg_q.up_hold_max    <= cfg_wdata;
				REG_CONFIRM_WINDOW: cfg_q.confirm_window <= cfg_wdata;
				REG_ENTER_LEVEL:    cfg_q.enter_level    <= cfg_wdata[LVL_W-1:0];
				REG_EXIT_LEVEL:     cfg_q.exit_level     <= cfg_wdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	tgus_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.enter_level (cfg_q.enter_level),
		.exit_level  (cfg_q.exit_level),
		.entry       (f_entry)
	);

	tgus_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (f_entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (q_entry)
	);

	tgus_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_not_empty    (q_not_empty),
		.q_data         (q_entry),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.orientation    (orientation),
		.sequence_phase (sequence_phase),
		.step_leds      (step_leds),
		.error_lamp     (error_lamp),
		.success_lamp   (success_lamp)
	);

endmodule

// File: rtl/core/tgus_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt gesture front end
// Scales accelerometer samples, tracks orientation with hysteresis and turns
// each accepted transaction into a queue entry (tick or orientation event).
// ----------------------------------------------------------------------------
module tgus_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic                                    mode,
	input  logic signed [tgus_pkg::ACC_W-1:0]       accel_x,
	input  logic signed [tgus_pkg::ACC_W-1:0]       accel_y,
	input  logic signed [tgus_pkg::ACC_W-1:0]       accel_z,
	input  logic        [tgus_pkg::LVL_W-1:0]       enter_level,
	input  logic        [tgus_pkg::LVL_W-1:0]       exit_level,
	output tgus_pkg::qentry_t                       entry
);
	import tgus_pkg::*;

	orient_t                   orient_q;
	orient_t                   orient_d;
	event_t                    ev;
	logic                      leave;
	logic signed [CMP_W-1:0]   sx, sy, sz;
	logic signed [CMP_W-1:0]   en_p, en_n, ex_p, ex_n;

	always_comb begin
		sx   = CMP_W'(scale_acc(accel_x));
		sy   = CMP_W'(scale_acc(accel_y));
		sz   = CMP_W'(scale_acc(accel_z));
		en_p = $signed({{(CMP_W-LVL_W){1'b0}}, enter_level});
		ex_p = $signed({{(CMP_W-LVL_W){1'b0}}, exit_level});
		en_n = -en_p;
		ex_n = -ex_p;
	end

	always_comb begin
		orient_d = orient_q;
		ev       = EV_NONE;
		leave    = 1'b0;
		case (orient_q)
			OR_INTER: begin
				if (sz > en_p) begin
					orient_d = OR_FLAT;
					ev       = EV_FLAT;
				end else if (sz < en_n) begin
					orient_d = OR_OVER;
				end else if (sy < en_n) begin
					orient_d = OR_RIGHT;
					ev       = EV_RIGHT;
				end else if (sy > en_p) begin
					orient_d = OR_LEFT;
				end else if (sx < en_n) begin
					orient_d = OR_UP;
					ev       = EV_UP;
				end else if (sx > en_p) begin
					orient_d = OR_DOWN;
				end
			end
			OR_FLAT:  leave = sz < ex_p;
			OR_OVER:  leave = sz > ex_n;
			OR_RIGHT: leave = sy > ex_n;
			OR_LEFT:  leave = sy < ex_p;
			OR_UP:    leave = sx > ex_n;
			OR_DOWN:  leave = sx < ex_p;
			default:  orient_d = OR_INTER;
		endcase
		if (leave) begin
			orient_d = OR_INTER;
			ev       = EV_CHANGE;
		end
	end

	always_comb begin
		if (!mode) begin
			entry.tick   = 1'b1;
			entry.ev     = EV_NONE;
			entry.orient = orient_q;
		end else begin
			entry.tick   = 1'b0;
			entry.ev     = ev;
			entry.orient = orient_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= OR_INTER;
		end else if (accept && mode) begin
			orient_q <= orient_d;
		end
	end

`ifndef SYNTH
	a_orient_via_inter: assert property (@(posedge clk) disable iff (!arst_n)
		(orient_q != OR_INTER) |=> (orient_q == $past(orient_q) || orient_q == OR_INTER))
		else $error("orientation moved between two tilts without passing intermediate");
	a_change_only_on_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode && entry.ev == EV_CHANGE) |=> (orient_q == OR_INTER))
		else $error("change event without return to intermediate");
	a_tick_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode) |=> (orient_q == $past(orient_q)))
		else $error("tick altered orientation");
`endif

endmodule

// File: rtl/core/tgus_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt gesture decoupling queue
// Short register FIFO between the classifying front end and the sequencer.
// ----------------------------------------------------------------------------
module tgus_queue #(
	parameter int DEPTH = tgus_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tgus_pkg::qentry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output tgus_pkg::qentry_t pop_data
);
	import tgus_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	qentry_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
`endif

endmodule

// File: rtl/core/tgus_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt gesture sequencer back end
// Consumes ticks and events from the queue, runs the flat, right, up, flat
// timing checks and registers one result transaction per entry.
// ----------------------------------------------------------------------------
module tgus_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tgus_pkg::cfg_t      cfg,
	input  logic                q_not_empty,
	input  tgus_pkg::qentry_t   q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          orientation,
	output logic [2:0]          sequence_phase,
	output logic [2:0]          step_leds,
	output logic                error_lamp,
	output logic                success_lamp
);
	import tgus_pkg::*;

	phase_t          phase_q, phase_d;
	logic            conf_q, conf_d;
	logic [MS_W-1:0] elapsed_q, elapsed_d, el_inc;
	logic [MS_W-1:0] lo, hi;
	logic            has_hi;
	event_t          want;
	logic            out_valid_q;
	orient_t         out_orient_q;
	phase_t          out_phase_q;

	assign pop = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		phase_d   = phase_q;
		conf_d    = conf_q;
		elapsed_d = elapsed_q;
		el_inc    = (elapsed_q == MS_MAX) ? elapsed_q : elapsed_q + MS_W'(1);
		lo        = cfg.flat_hold_min;
		hi        = '0;
		has_hi    = 1'b0;
		want      = EV_RIGHT;
		case (phase_q)
			PH_RIGHT: begin
				lo     = cfg.right_hold_min;
				hi     = cfg.right_hold_max;
				has_hi = 1'b1;
				want   = EV_UP;
			end
			PH_UP: begin
				lo     = cfg.up_hold_min;
				hi     = cfg.up_hold_max;
				has_hi = 1'b1;
				want   = EV_FLAT;
			end
			default: ;
		endcase

		if (q_data.tick) begin
			if (phase_q inside {PH_FLAT, PH_RIGHT, PH_UP}) begin
				elapsed_d = el_inc;
				if (conf_q) begin
					if (el_inc >= cfg.confirm_window) begin
						phase_d = PH_SERR;
					end
				end else if (has_hi && el_inc >= hi) begin
					phase_d = PH_TERR;
				end
			end
		end else if (q_data.ev != EV_NONE) begin
			if (phase_q == PH_WAIT) begin
				if (q_data.ev == EV_FLAT) begin
					phase_d   = PH_FLAT;
					conf_d    = 1'b0;
					elapsed_d = '0;
				end
			end else if (phase_q inside {PH_FLAT, PH_RIGHT, PH_UP}) begin
				if (!conf_q) begin
					if (q_data.ev == EV_CHANGE) begin
						if (elapsed_q < lo || (has_hi && elapsed_q >= hi)) begin
							phase_d = PH_TERR;
						end else begin
							conf_d    = 1'b1;
							elapsed_d = '0;
							if (cfg.confirm_window == '0) begin
								phase_d = PH_SERR;
							end
						end
					end
				end else if (q_data.ev == want) begin
					conf_d    = 1'b0;
					elapsed_d = '0;
					case (phase_q)
						PH_FLAT:  phase_d = PH_RIGHT;
						PH_RIGHT: phase_d = PH_UP;
						default:  phase_d = PH_TRIG;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			conf_q      <= 1'b0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			phase_q     <= phase_d;
			conf_q      <= conf_d;
			elapsed_q   <= elapsed_d;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_orient_q <= q_data.orient;
			out_phase_q  <= phase_d;
		end
	end

	always_comb begin
		case (out_phase_q)
			PH_FLAT:  step_leds = 3'b001;
			PH_RIGHT: step_leds = 3'b011;
			PH_UP:    step_leds = 3'b111;
			default:  step_leds = 3'b000;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign orientation    = out_orient_q;
	assign sequence_phase = out_phase_q;
	assign error_lamp     = (out_phase_q == PH_TERR) || (out_phase_q == PH_SERR);
	assign success_lamp   = (out_phase_q == PH_TRIG);

`ifndef SYNTH
	a_latched_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRIG || phase_q == PH_TERR || phase_q == PH_SERR)
		|=> (phase_q == $past(phase_q)))
		else $error("latched phase left before reset");
	a_wait_not_confirming: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT) |-> !conf_q)
		else $error("confirming while waiting for flat");
	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_phase_q == phase_q))
		else $error("result phase differs from sequencer state");
	a_stalled_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_phase_q)))
		else $error("pending result overwritten");
`endif

endmodule
